FILE: src/utf8_glyph_layout_defines.svh
// ---------------------------------------------------------------------------
// utf8 glyph layout assertion macros
// shared property wrappers on clk_i with the active-low reset
// ---------------------------------------------------------------------------
`ifndef UTF8_GLYPH_LAYOUT_DEFINES_SVH
`define UTF8_GLYPH_LAYOUT_DEFINES_SVH

// checked property, off while reset is asserted
`define UGL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// checked property with an explicit disable condition
`define UGL_ASSERT_IF(lbl, dis, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff ((!rst_ni) || (dis)) (prop)) \
    else $error(msg);

`endif

FILE: src/ugl_pkg.sv
// ---------------------------------------------------------------------------
// ugl_pkg
// types, constants and microcode program of the utf8 glyph layout block
// ---------------------------------------------------------------------------
`default_nettype none

package ugl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TAB_AW      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = TAB_AW + 1;
  localparam int COORD_BITS  = 16;
  localparam int CODE_W      = 32;
  localparam int GW_W        = 8;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_TEXT  = 2'd2,
    OP_END   = 2'd3
  } opcode_e;

  typedef enum logic {
    RK_DRAW = 1'b0,
    RK_END  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [GW_W-1:0]   width;
  } entry_t;

  // microcode steps
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_FIRST  = 3'd1,
    ST_LAST   = 3'd2,
    ST_MID0   = 3'd3,
    ST_BISECT = 3'd4,
    ST_DRAW   = 3'd5,
    ST_END    = 3'd6
  } step_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_FIRST,
    RD_LAST,
    RD_MID
  } rd_e;

  typedef enum logic [1:0] {
    DO_NONE,
    DO_INIT,
    DO_BISECT
  } dop_e;

  typedef enum logic [2:0] {
    C_DISPATCH,
    C_EMPTY,
    C_LT,
    C_GT,
    C_BISECT,
    C_OUT_FREE
  } cond_e;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_DRAW,
    EM_END
  } emit_e;

  typedef struct packed {
    logic  in_rdy;
    rd_e   rd;
    dop_e  op;
    cond_e cond;
    emit_e emit;
    step_e t_true;
    step_e t_false;
  } ctl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic acc_text_done;
    logic acc_end;
    logic empty;
    logic code_lt;
    logic code_gt;
    logic code_eq;
    logic more;
    logic out_free;
  } sts_t;

  function automatic ctl_t ucode(step_e s);
    ctl_t w;
    w = '{in_rdy: 1'b0, rd: RD_NONE, op: DO_NONE, cond: C_EMPTY, emit: EM_NONE,
          t_true: ST_IDLE, t_false: ST_IDLE};
    unique case (s)
      ST_IDLE: begin
        w.in_rdy  = 1'b1;
        w.cond    = C_DISPATCH;
        w.t_true  = ST_FIRST;
        w.t_false = ST_END;
      end
      ST_FIRST: begin
        w.rd      = RD_FIRST;
        w.op      = DO_INIT;
        w.cond    = C_EMPTY;
        w.t_false = ST_LAST;
      end
      ST_LAST: begin
        w.rd      = RD_LAST;
        w.cond    = C_LT;
        w.t_false = ST_MID0;
      end
      ST_MID0: begin
        w.rd      = RD_MID;
        w.cond    = C_GT;
        w.t_false = ST_BISECT;
      end
      ST_BISECT: begin
        w.rd     = RD_MID;
        w.op     = DO_BISECT;
        w.cond   = C_BISECT;
        w.t_true = ST_DRAW;
      end
      ST_DRAW: begin
        w.emit = EM_DRAW;
        w.cond = C_OUT_FREE;
      end
      ST_END: begin
        w.emit = EM_END;
        w.cond = C_OUT_FREE;
      end
      default: begin
        w.cond = C_EMPTY;
      end
    endcase
    return w;
  endfunction

  // bytes still to come after a lead byte
  function automatic logic [1:0] lead_len(logic [7:0] b);
    logic [1:0] n;
    if ((b & 8'hf8) == 8'hf0) begin
      n = 2'd3;
    end else if ((b & 8'hf0) == 8'he0) begin
      n = 2'd2;
    end else if ((b & 8'he0) == 8'hc0) begin
      n = 2'd1;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: src/ugl_glyph_ram.sv
// ---------------------------------------------------------------------------
// ugl_glyph_ram
// glyph table storage, one write port and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module ugl_glyph_ram
  import ugl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [TAB_AW-1:0] waddr_i,
  input  wire entry_t            wdata_i,
  input  wire logic              re_i,
  input  wire logic [TAB_AW-1:0] raddr_i,
  output entry_t                 rdata_o
);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/ugl_useq.sv
// ---------------------------------------------------------------------------
// ugl_useq
// step counter and control store, picks the next step from datapath flags
// ---------------------------------------------------------------------------
`default_nettype none

module ugl_useq
  import ugl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire sts_t sts_i,
  output ctl_t      ctl_o
);

  step_e pc_q, pc_d;
  ctl_t  ctl;

  assign ctl   = ucode(pc_q);
  assign ctl_o = ctl;

  always_comb begin
    pc_d = pc_q;
    unique case (ctl.cond)
      C_DISPATCH: begin
        if (sts_i.acc_text_done) begin
          pc_d = ctl.t_true;
        end else if (sts_i.acc_end) begin
          pc_d = ctl.t_false;
        end
      end
      C_EMPTY:  pc_d = sts_i.empty   ? ctl.t_true : ctl.t_false;
      C_LT:     pc_d = sts_i.code_lt ? ctl.t_true : ctl.t_false;
      C_GT:     pc_d = sts_i.code_gt ? ctl.t_true : ctl.t_false;
      C_BISECT: begin
        if (sts_i.code_eq) begin
          pc_d = ctl.t_true;
        end else if (!sts_i.more) begin
          pc_d = ctl.t_false;
        end
      end
      C_OUT_FREE: begin
        if (sts_i.out_free) begin
          pc_d = ctl.t_true;
        end
      end
      default: pc_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/utf8_glyph_layout.sv
// ---------------------------------------------------------------------------
// utf8_glyph_layout
// groups utf-8 byte sequences, binary-searches a glyph table, lays out pens
// ---------------------------------------------------------------------------
//
//   channel   signals                            direction
//   -------   --------------------------------   ---------
//   in        in_valid_i / in_ready_o + fields   sink
//   out       out_valid_o / out_ready_i + fields source
//   cfg       cfg_we_i / cfg_wdata_i             write only
//
// load, begin and a non-final text byte are handled in the idle step.
// a text byte that completes a code runs the first, last and mid0 steps, then
// the bisect step once per probe (at most 9 probes for a full table) and, on a
// hit, the draw step; a miss ends at a bisect probe, or sooner at the range checks.
// an end beat runs the end step; a result stalls the program only when the
// output register is still full, a new beat is accepted while a result waits.
// reset clears the step counter, pen, line, width sum, partial code and count;
// the table itself is not cleared and must be loaded before it is searched.
//
`default_nettype none

`include "utf8_glyph_layout_defines.svh"

module utf8_glyph_layout
  import ugl_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [CNT_W-1:0]      cfg_wdata_i,
  // input beats
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [TAB_AW-1:0]     entry_index_i,
  input  wire logic [CODE_W-1:0]     entry_code_i,
  input  wire logic [GW_W-1:0]       entry_width_i,
  input  wire logic [7:0]            text_byte_i,
  input  wire logic [COORD_BITS-1:0] start_x_i,
  input  wire logic [COORD_BITS-1:0] start_y_i,
  // result beats
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       result_kind_o,
  output logic [TAB_AW-1:0]          glyph_index_o,
  output logic [CODE_W-1:0]          glyph_code_o,
  output logic [COORD_BITS-1:0]      x_pos_o,
  output logic [COORD_BITS-1:0]      y_pos_o,
  output logic [COORD_BITS-1:0]      string_width_o
);

  ctl_t ctl;
  sts_t sts;

  // configuration and layout state
  logic [CNT_W-1:0]      glyph_count_q;
  logic [CNT_W-1:0]      count;
  logic [CODE_W-1:0]     partial_q, partial_d;
  logic [1:0]            pend_q, pend_d;
  logic [COORD_BITS-1:0] pen_x_q, pen_x_d;
  logic [COORD_BITS-1:0] line_y_q, line_y_d;
  logic [COORD_BITS-1:0] wsum_q, wsum_d;

  // search state: half-open range [lo, hi)
  logic [CNT_W-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [TAB_AW-1:0]     mid_q, mid_d;
  logic [CNT_W:0]        mid_sum;

  // table port
  logic                  ram_we, ram_re;
  logic [TAB_AW-1:0]     ram_raddr;
  entry_t                ram_wdata, ram_rdata;

  // output register
  logic                  out_valid_q;
  logic                  out_kind_q;
  logic [TAB_AW-1:0]     out_index_q;
  logic [CODE_W-1:0]     out_code_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q, out_w_q;

  logic                  accept, out_free, fire, fire_draw;
  logic [COORD_BITS-1:0] adv;
  opcode_e               opc;

  assign opc        = opcode_e'(opcode_i);
  assign in_ready_o = ctl.in_rdy;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = (ctl.emit != EM_NONE) && out_free;
  assign fire_draw  = (ctl.emit == EM_DRAW) && out_free;

  // a count above the table depth means the full table
  assign count = (glyph_count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : glyph_count_q;

  assign adv = COORD_BITS'(ram_rdata.width) + COORD_BITS'(1);

  ugl_useq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  assign ram_we    = accept && (opc == OP_LOAD);
  assign ram_wdata = '{code: entry_code_i, width: entry_width_i};
  assign ram_re    = (ctl.rd != RD_NONE);

  ugl_glyph_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_index_i),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // byte grouping and pen setup on accepted beats, pen advance on each draw
  always_comb begin
    partial_d = partial_q;
    pend_d    = pend_q;
    pen_x_d   = pen_x_q;
    line_y_d  = line_y_q;
    wsum_d    = wsum_q;
    if (accept) begin
      unique case (opc)
        OP_BEGIN: begin
          pen_x_d   = start_x_i;
          line_y_d  = start_y_i;
          wsum_d    = '0;
          partial_d = '0;
          pend_d    = '0;
        end
        OP_END: begin
          // a partial sequence is dropped, the pen stays
          partial_d = '0;
          pend_d    = '0;
        end
        OP_TEXT: begin
          if (pend_q == 2'd0) begin
            partial_d = CODE_W'(text_byte_i);
            pend_d    = lead_len(text_byte_i);
          end else begin
            partial_d = {partial_q[CODE_W-9:0], text_byte_i};
            pend_d    = pend_q - 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
    if (fire_draw) begin
      pen_x_d = pen_x_q + adv;
      wsum_d  = wsum_q + adv;
    end
  end

  // bisection update, midpoint rounded down
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    unique case (ctl.op)
      DO_INIT: begin
        lo_d = '0;
        hi_d = count;
      end
      DO_BISECT: begin
        if (sts.code_gt) begin
          lo_d = CNT_W'(mid_q) + CNT_W'(1);
        end else if (sts.code_lt) begin
          hi_d = CNT_W'(mid_q);
        end
      end
      default: begin
      end
    endcase
    mid_sum = {1'b0, lo_d} + {1'b0, hi_d} - (CNT_W+1)'(1);
    mid_d   = mid_sum[TAB_AW:1];
  end

  always_comb begin
    unique case (ctl.rd)
      RD_FIRST: ram_raddr = '0;
      RD_LAST:  ram_raddr = TAB_AW'(count - CNT_W'(1));
      RD_MID:   ram_raddr = mid_d;
      default:  ram_raddr = mid_q;
    endcase
  end

  assign sts.acc_text_done = accept && (opc == OP_TEXT) && (pend_d == 2'd0);
  assign sts.acc_end       = accept && (opc == OP_END);
  assign sts.empty         = (count == '0);
  assign sts.code_lt       = partial_q < ram_rdata.code;
  assign sts.code_gt       = partial_q > ram_rdata.code;
  assign sts.code_eq       = partial_q == ram_rdata.code;
  assign sts.more          = lo_d < hi_d;
  assign sts.out_free      = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_count_q <= '0;
      partial_q     <= '0;
      pend_q        <= '0;
      pen_x_q       <= '0;
      line_y_q      <= '0;
      wsum_q        <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
      mid_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        glyph_count_q <= cfg_wdata_i;
      end
      partial_q <= partial_d;
      pend_q    <= pend_d;
      pen_x_q   <= pen_x_d;
      line_y_q  <= line_y_d;
      wsum_q    <= wsum_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      if (ctl.rd == RD_MID) begin
        mid_q <= mid_d;
      end
    end
  end

  // output register, refilled in the same cycle it drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (fire_draw) begin
        out_kind_q  <= RK_DRAW;
        out_index_q <= mid_q;
        out_code_q  <= partial_q;
        out_x_q     <= pen_x_q;
        out_y_q     <= line_y_q;
        out_w_q     <= '0;
      end else begin
        out_kind_q  <= RK_END;
        out_index_q <= '0;
        out_code_q  <= '0;
        out_x_q     <= '0;
        out_y_q     <= '0;
        out_w_q     <= wsum_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_kind_q;
  assign glyph_index_o  = out_index_q;
  assign glyph_code_o   = out_code_q;
  assign x_pos_o        = out_x_q;
  assign y_pos_o        = out_y_q;
  assign string_width_o = out_w_q;

  // the search range stays non-empty and inside the valid entries
  `UGL_ASSERT(a_range_ok, (ctl.op == DO_BISECT) |-> (lo_q < hi_q) && (hi_q <= count),
    "bisection range empty or beyond glyph count")
  // the probed slot lies inside the range
  `UGL_ASSERT(a_mid_ok, (ctl.op == DO_BISECT) |-> (CNT_W'(mid_q) >= lo_q) &&
    (CNT_W'(mid_q) < hi_q), "bisection probe outside range")
  // a draw moves the pen by the glyph width plus one
  `UGL_ASSERT(a_pen_adv, fire_draw |=> pen_x_q == $past(pen_x_q + adv),
    "pen not advanced by glyph width plus one")
  // a draw only follows an exact code match
  `UGL_ASSERT_IF(a_draw_hit, 1'b0, (ctl.emit == EM_DRAW) |-> (partial_q == ram_rdata.code),
    "draw issued without a matching table code")

endmodule

`default_nettype wire

FILE: sim/tb_utf8_glyph_layout.sv
// ---------------------------------------------------------------------------
// tb_utf8_glyph_layout
// self-checking bench: loads glyph tables, streams text through the layout
// block and compares every draw command and end report with a local
// prediction of grouping, bisection search and pen advance
// ---------------------------------------------------------------------------
module tb_utf8_glyph_layout;
  import ugl_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;   // long receiver back-pressure
  localparam int RANDOM_BEATS  = 2000;

  // one input beat, every field carried even when the opcode ignores it
  typedef struct {
    opcode_e               op;
    logic [TAB_AW-1:0]     idx;
    logic [CODE_W-1:0]     code;
    logic [GW_W-1:0]       wid;
    logic [7:0]            tbyte;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
  } text_beat_t;

  // one result beat: a draw command or an end-of-string report
  typedef struct {
    kind_e                 kind;
    logic [TAB_AW-1:0]     slot;
    logic [CODE_W-1:0]     code;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] width;
  } draw_cmd_t;

  // dut ports, all inputs known from time zero
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            opcode_i       = '0;
  logic [TAB_AW-1:0]     entry_index_i  = '0;
  logic [CODE_W-1:0]     entry_code_i   = '0;
  logic [GW_W-1:0]       entry_width_i  = '0;
  logic [7:0]            text_byte_i    = '0;
  logic [COORD_BITS-1:0] start_x_i      = '0;
  logic [COORD_BITS-1:0] start_y_i      = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic                  result_kind_o;
  logic [TAB_AW-1:0]     glyph_index_o;
  logic [CODE_W-1:0]     glyph_code_o;
  logic [COORD_BITS-1:0] x_pos_o;
  logic [COORD_BITS-1:0] y_pos_o;
  logic [COORD_BITS-1:0] string_width_o;

  // predicted layout state, mirrors the block after each accepted beat
  logic [CODE_W-1:0]     tbl_code  [TABLE_DEPTH];
  logic [GW_W-1:0]       tbl_width [TABLE_DEPTH];
  logic [CODE_W-1:0]     seq_code      = '0;
  logic [1:0]            seq_left      = '0;
  logic [COORD_BITS-1:0] pen_col       = '0;
  logic [COORD_BITS-1:0] pen_row       = '0;
  logic [COORD_BITS-1:0] run_width     = '0;
  int                    active_glyphs = 0;

  text_beat_t beat_q[$];      // beats waiting for the driver
  draw_cmd_t  draws_due[$];   // predicted results, oldest first
  int         stim_count = 0;
  int         errors     = 0;

  // codes of the table loaded in the current phase
  logic [CODE_W-1:0] fresh [TABLE_DEPTH];
  int                fresh_count = 0;

  // receiver long-stall request from the stimulus thread
  bit hold_request = 1'b0;

  always #10 clk_i = ~clk_i;

  utf8_glyph_layout dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .entry_index_i  (entry_index_i),
    .entry_code_i   (entry_code_i),
    .entry_width_i  (entry_width_i),
    .text_byte_i    (text_byte_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .glyph_index_o  (glyph_index_o),
    .glyph_code_o   (glyph_code_o),
    .x_pos_o        (x_pos_o),
    .y_pos_o        (y_pos_o),
    .string_width_o (string_width_o)
  );

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------

  // continuation bytes still owed after a lead byte
  function automatic logic [1:0] seq_tail(logic [7:0] b);
    casez (b)
      8'b11110???: return 2'd3;
      8'b1110????: return 2'd2;
      8'b110?????: return 2'd1;
      default:     return 2'd0;
    endcase
  endfunction

  // bisection over the inclusive range, midpoint rounded down
  function automatic bit find_slot(input logic [CODE_W-1:0] key, output int slot);
    int n;
    int lo;
    int hi;
    int mid;
    n    = (active_glyphs > TABLE_DEPTH) ? TABLE_DEPTH : active_glyphs;
    lo   = 0;
    hi   = n - 1;
    mid  = 0;
    slot = 0;
    if (n == 0) return 1'b0;
    // outside first..last is a miss without probing
    if (key < tbl_code[0] || key > tbl_code[n-1]) return 1'b0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_code[mid] < key) lo = mid + 1;
      else if (tbl_code[mid] > key) hi = mid - 1;
      else break;
    end
    slot = mid;
    return tbl_code[mid] == key;
  endfunction

  // apply one accepted beat, queue the result it causes, if any
  task automatic layout_beat(input text_beat_t b);
    draw_cmd_t             cmd;
    int                    slot;
    logic [COORD_BITS-1:0] adv;
    cmd = '{kind: RK_DRAW, slot: '0, code: '0, x: '0, y: '0, width: '0};
    case (b.op)
      OP_LOAD: begin
        tbl_code[b.idx]  = b.code;
        tbl_width[b.idx] = b.wid;
      end
      OP_BEGIN: begin
        pen_col   = b.sx;
        pen_row   = b.sy;
        run_width = '0;
        seq_code  = '0;
        seq_left  = '0;
      end
      OP_END: begin
        // partial sequence dropped, pen kept
        cmd.kind  = RK_END;
        cmd.width = run_width;
        draws_due.push_back(cmd);
        seq_code  = '0;
        seq_left  = '0;
      end
      default: begin
        if (seq_left == 2'd0) begin
          seq_code = {24'd0, b.tbyte};
          seq_left = seq_tail(b.tbyte);
        end else begin
          // appended unchecked, big-endian
          seq_code = {seq_code[CODE_W-9:0], b.tbyte};
          seq_left = seq_left - 2'd1;
        end
        if (seq_left == 2'd0 && find_slot(seq_code, slot)) begin
          cmd.slot  = slot[TAB_AW-1:0];
          cmd.code  = seq_code;
          cmd.x     = pen_col;
          cmd.y     = pen_row;
          draws_due.push_back(cmd);
          adv       = COORD_BITS'(tbl_width[slot]) + COORD_BITS'(1);
          pen_col   = pen_col + adv;
          run_width = run_width + adv;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // random filler in the fields the opcode does not use
  function automatic text_beat_t noise_beat(opcode_e op);
    text_beat_t b;
    b.op    = op;
    b.idx   = TAB_AW'($urandom);
    b.code  = $urandom;
    b.wid   = GW_W'($urandom);
    b.tbyte = 8'($urandom);
    b.sx    = COORD_BITS'($urandom);
    b.sy    = COORD_BITS'($urandom);
    return b;
  endfunction

  task automatic push_beat(input text_beat_t b);
    beat_q.push_back(b);
    stim_count++;
  endtask

  task automatic push_load(input int idx, input logic [CODE_W-1:0] code,
                           input logic [GW_W-1:0] wid);
    text_beat_t b;
    b      = noise_beat(OP_LOAD);
    b.idx  = idx[TAB_AW-1:0];
    b.code = code;
    b.wid  = wid;
    push_beat(b);
  endtask

  task automatic push_begin(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    text_beat_t b;
    b    = noise_beat(OP_BEGIN);
    b.sx = x;
    b.sy = y;
    push_beat(b);
  endtask

  task automatic push_byte(input logic [7:0] c);
    text_beat_t b;
    b       = noise_beat(OP_TEXT);
    b.tbyte = c;
    push_beat(b);
  endtask

  task automatic push_end();
    push_beat(noise_beat(OP_END));
  endtask

  // send a code as its bytes, most significant non-zero byte first
  task automatic push_glyph(input logic [CODE_W-1:0] code);
    int nbytes;
    if (code[31:24] != 8'd0) nbytes = 4;
    else if (code[23:16] != 8'd0) nbytes = 3;
    else if (code[15:8] != 8'd0) nbytes = 2;
    else nbytes = 1;
    for (int i = nbytes - 1; i >= 0; i--) push_byte(code[8*i +: 8]);
  endtask

  // a code of a random length class, its lead byte matching the class
  function automatic logic [CODE_W-1:0] pick_code();
    logic [31:0] r;
    logic [7:0]  c;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: begin
        c = r[7:0];
        while (seq_tail(c) != 2'd0) c = 8'($urandom);
        return {24'd0, c};
      end
      1:       return {16'd0, 3'b110, r[12:0]};
      2:       return {8'd0, 4'he, r[19:0]};
      default: return {5'b11110, r[26:0]};
    endcase
  endfunction

  // load slots 0..n-1, plus a few stray writes above the searched range
  task automatic build_table(input int n, input bit sorted);
    logic [CODE_W-1:0] key;
    int                j;
    for (int i = 0; i < n; i++) fresh[i] = pick_code();
    if (sorted) begin
      for (int i = 1; i < n; i++) begin
        key = fresh[i];
        j   = i - 1;
        while (j >= 0 && fresh[j] > key) begin
          fresh[j+1] = fresh[j];
          j--;
        end
        fresh[j+1] = key;
      end
    end
    fresh_count = n;
    for (int i = 0; i < n; i++) push_load(i, fresh[i], GW_W'($urandom));
    if (n < TABLE_DEPTH) begin
      repeat ($urandom_range(0, 4)) begin
        push_load($urandom_range(n, TABLE_DEPTH - 1), $urandom, GW_W'($urandom));
      end
    end
  endtask

  // random strings: mostly known glyphs, some noise and broken sequences
  task automatic push_strings(input int quota);
    int start;
    int lim;
    start = stim_count;
    lim   = (active_glyphs < fresh_count) ? active_glyphs : fresh_count;
    while (stim_count - start < quota) begin
      // now and then text runs on without a fresh begin
      if ($urandom_range(0, 15) != 0) begin
        push_begin(COORD_BITS'($urandom), COORD_BITS'($urandom));
      end
      repeat ($urandom_range(1, 12)) begin
        if (lim > 0 && $urandom_range(0, 4) != 0) push_glyph(fresh[$urandom_range(0, lim - 1)]);
        else push_byte(8'($urandom));
      end
      // dangling lead byte, c0..f7
      if ($urandom_range(0, 5) == 0) push_byte(8'(8'hc0 + $urandom_range(0, 55)));
      if ($urandom_range(0, 9) != 0) push_end();
    end
  endtask

  // sender pause: everything accepted, every result back, block settled
  task automatic wait_drained();
    while (beat_q.size() != 0 || draws_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only ever while idle
  task automatic set_glyph_count(input int v);
    @(posedge clk_i);
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= v[CNT_W-1:0];
    active_glyphs  = v & ((1 << CNT_W) - 1);
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
  endtask

  function automatic void check_field(string what, logic [CODE_W-1:0] want,
                                      logic [CODE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // driver: bursts of beats with random gaps, payload held until accepted
  // ---------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin : source
    logic       nxt_valid;
    text_beat_t b;
    nxt_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        layout_beat(beat_q.pop_front());
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (beat_q.size() != 0) begin
          b              = beat_q[0];
          opcode_i      <= b.op;
          entry_index_i <= b.idx;
          entry_code_i  <= b.code;
          entry_width_i <= b.wid;
          text_byte_i   <= b.tbyte;
          start_x_i     <= b.sx;
          start_y_i     <= b.sy;
          nxt_valid      = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // a quarter of the bursts run straight into the next one
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------
  // monitor: checks each result beat, stalls on a pattern of its own
  // ---------------------------------------------------------------------
  int hold_left  = 0;
  int ready_mode = 0;

  always @(posedge clk_i) begin : sink
    draw_cmd_t want;
    logic      nxt_ready;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (draws_due.size() == 0) begin
          $display("%0t: result beat with none pending, kind %0d code %0h width %0h",
                   $time, result_kind_o, glyph_code_o, string_width_o);
          errors++;
        end else begin
          want = draws_due.pop_front();
          check_field("result_kind", CODE_W'(want.kind), CODE_W'(result_kind_o));
          check_field("glyph_index", CODE_W'(want.slot), CODE_W'(glyph_index_o));
          check_field("glyph_code", want.code, glyph_code_o);
          check_field("x_pos", CODE_W'(want.x), CODE_W'(x_pos_o));
          check_field("y_pos", CODE_W'(want.y), CODE_W'(y_pos_o));
          check_field("string_width", CODE_W'(want.width), CODE_W'(string_width_o));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (hold_request) begin
        // long hold-off so the block backs up into its input
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        nxt_ready    = 1'b0;
      end else begin
        if ($urandom_range(0, 199) == 0) ready_mode = $urandom_range(0, 2);
        case (ready_mode)
          0:       nxt_ready = 1'b1;
          1:       nxt_ready = 1'($urandom_range(0, 1));
          default: nxt_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ready_i <= nxt_ready;
    end
  end

  // watchdog
  int cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("utf8_glyph_layout: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    int n;
    int count;
    bit sorted;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table after reset: all misses, end report of zero width
    push_byte(8'h41);
    push_byte(8'hc3);
    push_end();
    // small sorted table, one code of each length class plus a stray
    // continuation byte, widths at both extremes
    push_load(0, 32'h0000_0041, 8'd0);
    push_load(1, 32'h0000_0080, 8'd1);
    push_load(2, 32'h0000_c3a9, 8'd255);
    push_load(3, 32'h00e2_82ac, 8'd7);
    push_load(4, 32'hf09f_9880, 8'd3);
    wait_drained();
    set_glyph_count(5);

    push_byte(8'h41);                      // before any begin, pen at origin
    push_begin(16'hfff0, 16'hffff);
    push_byte(8'hc3);                      // two-byte hit, pen wraps past ffff
    push_byte(8'ha9);
    push_byte(8'h80);                      // lone continuation byte as a code
    push_byte(8'h00);                      // below the first entry
    push_byte(8'hff);                      // between entries, bisection miss
    push_glyph(32'hf09f_9880);
    push_glyph(32'h00e2_82ac);
    push_byte(8'hc3);                      // begin drops the partial sequence
    push_begin(16'h0000, 16'h0000);
    push_byte(8'h41);
    push_byte(8'he2);                      // end drops the partial sequence
    push_byte(8'h82);
    push_end();
    wait_drained();

    // random phases, each with its own table and count setting
    phase = 0;
    while (phase < 8 || stim_count < RANDOM_BEATS) begin
      sorted = 1'b1;
      case (phase % 8)
        0:       begin n = 0;                      count = 0; end
        1:       begin n = 1;                      count = 1; end
        2:       begin n = TABLE_DEPTH;            count = TABLE_DEPTH; end
        3:       begin n = $urandom_range(2, 16);  count = n; end
        4:       begin n = $urandom_range(17, 64); count = n; end
        // count beyond the table depth acts as a full table
        5:       begin n = TABLE_DEPTH;            count = $urandom_range(TABLE_DEPTH + 1, 511); end
        6:       begin n = $urandom_range(2, 24);  count = n; sorted = 1'b0; end
        default: begin n = $urandom_range(3, 10);  count = n; end
      endcase
      build_table(n, sorted);
      wait_drained();
      set_glyph_count(count);
      if (phase % 4 == 2) hold_request = 1'b1;
      push_strings($urandom_range(150, 250));
      wait_drained();
      phase++;
    end

    if (errors == 0) begin
      $display("utf8_glyph_layout: match");
    end else begin
      $display("utf8_glyph_layout: mismatch");
    end
    $finish;
  end

endmodule
